// File: sv/size_class_fit_allocator_defines.svh
// ---------------------------------------------------------------------------
// size_class_fit_allocator_defines.svh
// Assertion macros shared by the allocator files.
// ---------------------------------------------------------------------------
`ifndef SIZE_CLASS_FIT_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_FIT_ALLOCATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SFA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define SFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Check that expr holds in every cycle out of reset.
`define SFA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`endif

// File: sv/sfa_pkg.sv
// ---------------------------------------------------------------------------
// sfa_pkg
// Types and constants of the size class fit allocator.
// ---------------------------------------------------------------------------
package sfa_pkg;

   localparam int MAX_CLASSES = 16;
   localparam int SIZE_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int STATUS_W    = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 2'd0,
      ST_REFUSED = 2'd1,
      ST_LOADED  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   // One table entry as held in a cell and shifted to its neighbor.
   typedef struct packed {
      logic               valid;
      logic [SIZE_W-1:0]  size;
      logic [COUNT_W-1:0] free;
   } entry_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic               load;
      logic               request;
      logic [SIZE_W-1:0]  new_size;
      logic [COUNT_W-1:0] new_free;
      logic [SIZE_W-1:0]  req_size;
   } cell_ctrl_type;

   // Search result handed down the row.
   typedef struct packed {
      logic              found;
      logic [SIZE_W-1:0] hit_size;
   } link_type;

endpackage

// File: sv/sfa_cell.sv
// ---------------------------------------------------------------------------
// sfa_cell
// One slot of the sorted class row: holds one entry, shifts on insert.
// ---------------------------------------------------------------------------
module sfa_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sfa_pkg::cell_ctrl_type ctrl,
   input  sfa_pkg::entry_type    prev_entry,
   input  logic                  prev_gt,
   input  sfa_pkg::link_type     link_in,
   output sfa_pkg::entry_type    entry,
   output logic                  gt,
   output sfa_pkg::link_type     link_out
);
   import sfa_pkg::*;

   logic               valid_ff, valid_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic               match;
   logic               hit;

   // Empty slots count as larger than anything so inserts land at the tail.
   assign gt    = !valid_ff || (size_ff > ctrl.new_size);
   assign match = valid_ff && (free_ff != '0) && (size_ff >= ctrl.req_size);
   assign hit   = match && !link_in.found;

   assign link_out.found    = link_in.found || match;
   assign link_out.hit_size = hit ? size_ff : link_in.hit_size;

   assign entry.valid = valid_ff;
   assign entry.size  = size_ff;
   assign entry.free  = free_ff;

   always_comb begin
      valid_in = valid_ff;
      size_in  = size_ff;
      free_in  = free_ff;
      if (ctrl.load && gt) begin
         // shift the left neighbor in, or take the new class here
         if (prev_gt) begin
            valid_in = prev_entry.valid;
            size_in  = prev_entry.size;
            free_in  = prev_entry.free;
         end else begin
            valid_in = 1'b1;
            size_in  = ctrl.new_size;
            free_in  = ctrl.new_free;
         end
      end else if (ctrl.request && hit) begin
         free_in = free_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      size_ff <= size_in;
      free_ff <= free_in;
   end

endmodule

// File: sv/size_class_fit_allocator.sv
// ---------------------------------------------------------------------------
// size_class_fit_allocator
// Best-fit allocator over a table of size classes kept as a sorted cell row.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item: operation 0 loads a class (class_size,
//   class_count), operation 1 asks for a block of request_size. rsp_* returns
//   exactly one word per item: status and granted_size.
//   Classes sit in a row of cells sorted by size, equal sizes in load order,
//   so the first cell with a free block and a large enough size is the best
//   fit. Loads insert by shifting larger entries one cell to the right.
//   An accepted word waits in the holding register until the output
//   register is free or draining; the cell row then processes it and the
//   response is registered. The holding register takes a new word only
//   after the cell row has processed the last one.
//   Reset clears the valid bit of every cell at once; no sweep.
//   When rsp_ready is low the response holds in its output register, one
//   more word may be accepted and waits in the holding register, and then
//   req_ready stays low until the response is taken.
// ---------------------------------------------------------------------------
`include "size_class_fit_allocator_defines.svh"

module size_class_fit_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [sfa_pkg::SIZE_W-1:0]    req_class_size,
   input  logic [sfa_pkg::COUNT_W-1:0]   req_class_count,
   input  logic [sfa_pkg::SIZE_W-1:0]    req_request_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sfa_pkg::SIZE_W-1:0]    rsp_granted_size
);
   import sfa_pkg::*;

   localparam logic [MAX_CLASSES-1:0] ONE_VEC = MAX_CLASSES'(1);

   // holding register for the accepted word
   logic               busy_ff, busy_in;
   op_type             op_ff, op_in;
   logic [SIZE_W-1:0]  csize_ff, csize_in;
   logic [COUNT_W-1:0] ccount_ff, ccount_in;
   logic [SIZE_W-1:0]  rsize_ff, rsize_in;

   // response output register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]  rsp_size_ff, rsp_size_in;

   logic               accept;
   logic               exec;
   logic               full;
   cell_ctrl_type      ctrl;

   entry_type          entry_vec [MAX_CLASSES];
   logic [MAX_CLASSES-1:0] gt_vec;
   logic [MAX_CLASSES-1:0] valid_vec;
   link_type           link_vec  [MAX_CLASSES];

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   // process the held word once the output register is free or draining
   assign exec      = busy_ff && (!rsp_valid_ff || rsp_ready);
   // table is full once the last cell holds a class
   assign full      = entry_vec[MAX_CLASSES-1].valid;

   assign ctrl.load     = exec && (op_ff == OP_LOAD) && !full;
   assign ctrl.request  = exec && (op_ff == OP_REQUEST);
   assign ctrl.new_size = csize_ff;
   assign ctrl.new_free = ccount_ff;
   assign ctrl.req_size = rsize_ff;

   // Cell row: entries shift right on insert, search result flows right.
   for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
      entry_type prev_entry;
      logic      prev_gt;
      link_type  link_in;

      if (i == 0) begin : g_head
         assign prev_entry = '0;
         assign prev_gt    = 1'b0;
         assign link_in    = '0;
      end else begin : g_body
         assign prev_entry = entry_vec[i-1];
         assign prev_gt    = gt_vec[i-1];
         assign link_in    = link_vec[i-1];
      end

      sfa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_entry),
         .prev_gt    (prev_gt),
         .link_in    (link_in),
         .entry      (entry_vec[i]),
         .gt         (gt_vec[i]),
         .link_out   (link_vec[i])
      );

      assign valid_vec[i] = entry_vec[i].valid;
   end

   always_comb begin
      busy_in       = busy_ff;
      op_in         = op_ff;
      csize_in      = csize_ff;
      ccount_in     = ccount_ff;
      rsize_in      = rsize_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_size_in   = rsp_size_ff;

      // drop the response once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         busy_in   = 1'b1;
         op_in     = op_type'(req_operation);
         csize_in  = req_class_size;
         ccount_in = req_class_count;
         rsize_in  = req_request_size;
      end else if (exec) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_size_in  = '0;
         case (op_ff)
            OP_LOAD: begin
               rsp_status_in = full ? ST_FULL : ST_LOADED;
            end
            OP_REQUEST: begin
               if (link_vec[MAX_CLASSES-1].found) begin
                  rsp_status_in = ST_GRANTED;
                  rsp_size_in   = link_vec[MAX_CLASSES-1].hit_size;
               end else begin
                  rsp_status_in = ST_REFUSED;
               end
            end
            default: begin
               rsp_status_in = ST_REFUSED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      csize_ff      <= csize_in;
      ccount_ff     <= ccount_in;
      rsize_ff      <= rsize_in;
      rsp_status_ff <= rsp_status_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_size = rsp_size_ff;

   // an executed word always produces a response in the next cycle
   `SFA_ASSERT_NEXT(a_exec_resp, clock, reset, exec, rsp_valid_ff)
   // loaded classes always fill the row from the head
   `SFA_ASSERT_ALWAYS(a_row_packed, clock, reset, (valid_vec & (valid_vec + ONE_VEC)) == '0)
   // an accepted insert always finds the last cell empty, so nothing is pushed off the row
   `SFA_ASSERT_SAME(a_insert_lands, clock, reset, ctrl.load, gt_vec[MAX_CLASSES-1])
   // only a grant carries a nonzero size
   `SFA_ASSERT_SAME(a_size_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_GRANTED), rsp_size_ff == '0)

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the size class fit allocator: a directed table of
// loads and requests, then random words checked against a best-fit table
// kept alongside the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import sfa_pkg::*;

   // Stop the run once this many cycles pass with no word accepted and no response taken.
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_WORDS = 400;
   localparam int DIR_ROWS     = 25;

   // One request-side word plus, for rows where the answer is obvious,
   // the response typed in by hand.
   typedef struct packed {
      op_type              op;
      logic [SIZE_W-1:0]   csize;
      logic [COUNT_W-1:0]  ccount;
      logic [SIZE_W-1:0]   rsize;
      logic                typed;
      status_type          status;
      logic [SIZE_W-1:0]   granted;
   } stim_row_type;

   typedef struct packed {
      status_type          status;
      logic [SIZE_W-1:0]   granted;
   } rsp_word_type;

   // Directed table. Typed rows carry their answer; the rest are scored by
   // the best-fit table below.
   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      // request against an empty table, smallest and largest size
      '{OP_REQUEST, 32'h0,        16'h0,    32'h0,        1'b1, ST_REFUSED, 32'h0},
      '{OP_REQUEST, 32'h0,        16'h0,    32'hFFFF_FFFF, 1'b1, ST_REFUSED, 32'h0},
      // largest class with one block, then a class loaded empty
      '{OP_LOAD,    32'hFFFF_FFFF, 16'h1,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'h0,        16'h0,    32'h0,        1'b1, ST_LOADED,  32'h0},
      // zero request skips the empty class and takes the only free block
      '{OP_REQUEST, 32'h0,        16'h0,    32'h0,        1'b1, ST_GRANTED, 32'hFFFF_FFFF},
      // that class is now used up
      '{OP_REQUEST, 32'h0,        16'h0,    32'hFFFF_FFFF, 1'b1, ST_REFUSED, 32'h0},
      // two classes of equal size: the earlier one must serve
      '{OP_LOAD,    32'd1000,     16'd3,    32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd1000,     16'd20,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'h8000_0000, 16'hFFFF, 32'h0,       1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd10,       16'd25,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd999,      16'd15,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_REQUEST, 32'h0,        16'h0,    32'd1000,     1'b0, ST_GRANTED, 32'h0},
      '{OP_REQUEST, 32'h0,        16'h0,    32'd11,       1'b0, ST_GRANTED, 32'h0},
      '{OP_LOAD,    32'h7FFF_FFFF, 16'd30,  32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd1,        16'd10,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'h1234_5678, 16'd12,  32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd500,      16'd20,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'hFFFF_FFFE, 16'd2,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd64,       16'd18,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd65,       16'd16,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd4096,     16'd25,   32'h0,        1'b1, ST_LOADED,  32'h0},
      '{OP_LOAD,    32'd7,        16'd8,    32'h0,        1'b1, ST_LOADED,  32'h0},
      // table is full now: further loads bounce, whatever they carry
      '{OP_LOAD,    32'd3,        16'd1,    32'h0,        1'b1, ST_FULL,    32'h0},
      '{OP_LOAD,    32'hFFFF_FFFF, 16'hFFFF, 32'h0,       1'b1, ST_FULL,    32'h0},
      '{OP_REQUEST, 32'h0,        16'h0,    32'hFFFF_FFFF, 1'b0, ST_GRANTED, 32'h0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   logic [SIZE_W-1:0]    req_class_size;
   logic [COUNT_W-1:0]   req_class_count;
   logic [SIZE_W-1:0]    req_request_size;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SIZE_W-1:0]    rsp_granted_size;

   // Best-fit table mirrored on the bench side.
   logic [SIZE_W-1:0]    class_size_tab [MAX_CLASSES];
   logic [COUNT_W-1:0]   class_free_tab [MAX_CLASSES];
   int                   classes_loaded;

   rsp_word_type         awaited_words [$];
   int                   failures;
   int                   burst_left;
   int                   stall_mode;
   int                   stall_mode_left;

   size_class_fit_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_class_size   (req_class_size),
      .req_class_count  (req_class_count),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_size (rsp_granted_size)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one word to the best-fit table and return the response it owes.
   // Loads append until the table is full; a request takes the smallest
   // free class that fits, the earliest one on a tie.
   function automatic rsp_word_type predict_word(input stim_row_type w);
      rsp_word_type r;
      int           best;
      best      = -1;
      r.status  = ST_REFUSED;
      r.granted = '0;
      if (w.op == OP_LOAD) begin
         if (classes_loaded >= MAX_CLASSES) begin
            r.status = ST_FULL;
         end else begin
            class_size_tab[classes_loaded] = w.csize;
            class_free_tab[classes_loaded] = w.ccount;
            classes_loaded++;
            r.status = ST_LOADED;
         end
      end else begin
         for (int i = 0; i < classes_loaded; i++) begin
            // strict less-than keeps the earlier class on equal sizes
            if (class_free_tab[i] != '0 && class_size_tab[i] >= w.rsize &&
                (best < 0 || class_size_tab[i] < class_size_tab[best])) begin
               best = i;
            end
         end
         if (best >= 0) begin
            class_free_tab[best] = class_free_tab[best] - 1'b1;
            r.status  = ST_GRANTED;
            r.granted = class_size_tab[best];
         end
      end
      return r;
   endfunction

   // Drive one word and hold it until accepted. The sender runs in bursts:
   // at the start of each burst, drop valid for a random gap (possibly none).
   // Valid is never lowered and raised in the same step.
   task automatic offer_word(input stim_row_type w);
      int           gap;
      rsp_word_type owed;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_operation    <= w.op;
      req_class_size   <= w.csize;
      req_class_count  <= w.ccount;
      req_request_size <= w.rsize;
      do @(posedge clock); while (!(req_valid && req_ready));
      // Word accepted at this edge: advance the table and log the answer.
      owed = predict_word(w);
      if (w.typed) begin
         owed.status  = w.status;
         owed.granted = w.granted;
      end
      awaited_words.insert(awaited_words.size(), owed);
   endtask

   // Pick a request size near a loaded class (one below, equal, one above),
   // so that fits, ties and exhausted classes get hit over and over.
   function automatic logic [SIZE_W-1:0] size_near_class();
      logic [SIZE_W-1:0] base;
      if (classes_loaded == 0) return $urandom;
      base = class_size_tab[$urandom_range(0, classes_loaded - 1)];
      case ($urandom_range(0, 2))
         0: return base - 1'b1;
         1: return base;
         default: return base + 1'b1;
      endcase
   endfunction

   // Receiver: switch at random between stall patterns so
   // that back-pressure lands on every phase of the block's work.
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = $urandom_range(0, 2);
         stall_mode_left = $urandom_range(16, 80);
      end else begin
         stall_mode_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 9) < 7);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Score every accepted response against the oldest owed word.
   always @(posedge clock) begin
      rsp_word_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_words.size() == 0) begin
            $error("response with nothing outstanding: status %0d granted_size %0h",
                   rsp_status, rsp_granted_size);
            failures++;
         end else begin
            owed = awaited_words.pop_front();
            if (rsp_status !== owed.status) begin
               $error("status: expected %0d, got %0d", owed.status, rsp_status);
               failures++;
            end
            if (rsp_granted_size !== owed.granted) begin
               $error("granted_size: expected %0h, got %0h", owed.granted,
                      rsp_granted_size);
               failures++;
            end
         end
      end
   end

   // Watchdog: give up once nothing moves on either channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("size_class_fit_allocator test failed");
      $finish;
   end

   initial begin
      stim_row_type w;
      int           pick;
      failures         = 0;
      burst_left       = 0;
      stall_mode       = 0;
      stall_mode_left  = 0;
      classes_loaded   = 0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
         class_size_tab[i] = '0;
         class_free_tab[i] = '0;
      end
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= OP_LOAD;
      req_class_size   <= '0;
      req_class_count  <= '0;
      req_request_size <= '0;
      rsp_ready        <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the table.
      for (int i = 0; i < DIR_ROWS; i++) offer_word(DIR_TABLE[i]);

      // Random part. Mostly requests, sized around the loaded classes so
      // the small counts drain over the run; loads keep bouncing off the
      // full table with random content in every field.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         w       = '0;
         w.typed = 1'b0;
         if ($urandom_range(0, 99) < 15) begin
            w.op     = OP_LOAD;
            w.csize  = $urandom;
            w.ccount = COUNT_W'($urandom_range(0, 65535));
            w.rsize  = $urandom;
         end else begin
            w.op     = OP_REQUEST;
            w.csize  = $urandom;
            w.ccount = COUNT_W'($urandom_range(0, 65535));
            pick     = $urandom_range(0, 99);
            if (pick < 60) w.rsize = size_near_class();
            else if (pick < 75) w.rsize = '0;
            else w.rsize = $urandom;
         end
         offer_word(w);
      end
      req_valid <= 1'b0;

      // Drain the outstanding responses, then keep watching so that any stray
      // word still shows before the end.
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("size_class_fit_allocator test passed");
      end else begin
         $display("size_class_fit_allocator test failed");
      end
      $finish;
   end

endmodule
